// ===== hw/rtl/swmm_pkg.sv =====
// Shared types for the sliding window minimum and maximum block.
package swmm_pkg;

   typedef enum logic [2:0] {
      Q_IDLE,
      Q_POP_RD,
      Q_POP_CHK,
      Q_EXP_RD,
      Q_EXP_CHK,
      Q_PUSH,
      Q_FRONT_RD,
      Q_FRONT_CHK
   } q_state_type;

   typedef enum logic [1:0] {
      T_IDLE,
      T_RUN,
      T_WAIT
   } top_state_type;

   typedef struct packed {
      logic        busy;
      logic [31:0] front;
   } q_status_type;

endpackage

// ===== hw/rtl/swmm_queue.sv =====
// One monotonic queue kept as a circular buffer in a synchronous memory.
module swmm_queue #(
   parameter int DEPTH  = 256,
   parameter bit IS_MIN = 1'b1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  clear,
   input  logic                  start,
   input  logic [31:0]           sample,
   input  logic [31:0]           position,
   input  logic [31:0]           window,
   output swmm_pkg::q_status_type status
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   swmm_pkg::q_state_type state_ff, state_in;

   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] head_ff, head_in;
   logic [31:0]   front_ff, front_in;
   logic [31:0]   sample_ff, position_ff;

   logic [63:0]   mem [DEPTH];
   logic [63:0]   rd_ff;
   logic [AW-1:0] raddr, waddr;
   logic          we;
   logic [63:0]   wdata;
   logic          dominated, expired;

   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                              input logic [AW-1:0] off);
      logic [AW:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= (AW + 1)'(DEPTH)) begin
         sum = sum - (AW + 1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   assign dominated = IS_MIN ? ($signed(rd_ff[31:0]) >= $signed(sample_ff))
                             : ($signed(rd_ff[31:0]) <= $signed(sample_ff));
   assign expired   = (position_ff - rd_ff[63:32]) >= window;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         swmm_pkg::Q_IDLE:      if (start) state_in = swmm_pkg::Q_POP_RD;
         swmm_pkg::Q_POP_RD:    state_in = (count_ff == '0) ? swmm_pkg::Q_EXP_RD
                                                            : swmm_pkg::Q_POP_CHK;
         swmm_pkg::Q_POP_CHK:   state_in = dominated ? swmm_pkg::Q_POP_RD
                                                     : swmm_pkg::Q_EXP_RD;
         swmm_pkg::Q_EXP_RD:    state_in = (count_ff == '0) ? swmm_pkg::Q_PUSH
                                                            : swmm_pkg::Q_EXP_CHK;
         swmm_pkg::Q_EXP_CHK:   state_in = swmm_pkg::Q_PUSH;
         swmm_pkg::Q_PUSH:      state_in = swmm_pkg::Q_FRONT_RD;
         swmm_pkg::Q_FRONT_RD:  state_in = swmm_pkg::Q_FRONT_CHK;
         swmm_pkg::Q_FRONT_CHK: state_in = swmm_pkg::Q_IDLE;
         default:               state_in = swmm_pkg::Q_IDLE;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      front_in = front_ff;
      raddr    = head_ff;
      waddr    = wrap_add(head_ff, count_ff[AW-1:0]);
      we       = 1'b0;
      wdata    = {position_ff, sample_ff};
      case (state_ff)
         swmm_pkg::Q_POP_RD: begin
            raddr = wrap_add(head_ff, AW'(count_ff - 1'b1));
         end
         swmm_pkg::Q_POP_CHK: begin
            if (dominated) count_in = count_ff - 1'b1;
         end
         swmm_pkg::Q_EXP_CHK: begin
            if (expired) begin
               count_in = count_ff - 1'b1;
               head_in  = wrap_add(head_ff, AW'(1));
            end
         end
         swmm_pkg::Q_PUSH: begin
            we       = 1'b1;
            count_in = count_ff + 1'b1;
         end
         swmm_pkg::Q_FRONT_CHK: begin
            front_in = rd_ff[31:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= swmm_pkg::Q_IDLE;
         count_ff <= '0;
         head_ff  <= '0;
      end else if (clear) begin
         state_ff <= state_in;
         count_ff <= '0;
         head_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         head_ff  <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      front_ff <= front_in;
      if (start && state_ff == swmm_pkg::Q_IDLE) begin
         sample_ff   <= sample;
         position_ff <= position;
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   assign status.busy  = (state_ff != swmm_pkg::Q_IDLE);
   assign status.front = front_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH)) else $error("queue count above depth");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      state_ff == swmm_pkg::Q_PUSH |-> count_ff < CW'(DEPTH))
      else $error("push into full queue");
   a_push_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == swmm_pkg::Q_FRONT_RD |-> count_ff != '0)
      else $error("queue empty after push");

endmodule

// ===== hw/rtl/sliding_window_min_max_core.sv =====
// Sliding window minimum and maximum over a signed sample stream.
// Each sample is processed to completion before the next one is taken: each queue
// pops dominated entries from its back (each pop is one memory read and one
// compare), drops an expired front entry, pushes the sample and reads its front.
// A finished result waits while the receiver has not yet taken the previous one.
// Reset: synchronous; queues empty, window size 1, position zero, no result.
module sliding_window_min_max_core #(
   parameter int WINDOW_MAX = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_sample,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_window_min,
   output logic [31:0] rsp_window_max,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [8:0]  csr_window_size
);

   localparam int FW = $clog2(WINDOW_MAX + 1);

   swmm_pkg::top_state_type state_ff, state_in;
   swmm_pkg::q_status_type  min_status, max_status;

   logic [8:0]    window_size_ff;
   logic [31:0]   window;
   logic [31:0]   position_ff;
   logic [FW-1:0] fill_ff, fill_next;
   logic          emit_ff;
   logic          rsp_valid_ff;
   logic [31:0]   min_ff, max_ff;
   logic          req_xfer, csr_xfer, done, slot_free, load;

   // A configuration write is taken only while no sample is in flight, and
   // a pending write holds off the next sample so the two never share an edge.
   assign csr_ready = (state_ff == swmm_pkg::T_IDLE);
   assign csr_xfer  = csr_valid && csr_ready;
   assign req_ready = (state_ff == swmm_pkg::T_IDLE) && !csr_valid;
   assign req_xfer  = req_valid && req_ready;

   // Effective window: zero acts as one, large values saturate.
   always_comb begin
      if (window_size_ff == '0) begin
         window = 32'd1;
      end else if (32'(window_size_ff) > 32'(WINDOW_MAX)) begin
         window = 32'(WINDOW_MAX);
      end else begin
         window = 32'(window_size_ff);
      end
   end

   assign fill_next = (fill_ff < FW'(WINDOW_MAX)) ? fill_ff + 1'b1 : fill_ff;

   swmm_queue #(.DEPTH(WINDOW_MAX), .IS_MIN(1'b1)) u_min_queue (
      .clock(clock), .reset(reset), .clear(csr_xfer), .start(req_xfer),
      .sample(req_sample), .position(position_ff), .window(window),
      .status(min_status)
   );

   swmm_queue #(.DEPTH(WINDOW_MAX), .IS_MIN(1'b0)) u_max_queue (
      .clock(clock), .reset(reset), .clear(csr_xfer), .start(req_xfer),
      .sample(req_sample), .position(position_ff), .window(window),
      .status(max_status)
   );

   // Both queues have finished once neither reports busy.
   assign done      = !min_status.busy && !max_status.busy;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         swmm_pkg::T_IDLE: if (req_xfer) state_in = swmm_pkg::T_RUN;
         swmm_pkg::T_RUN: begin
            if (done) begin
               if (!emit_ff || slot_free) state_in = swmm_pkg::T_IDLE;
               else                       state_in = swmm_pkg::T_WAIT;
            end
         end
         swmm_pkg::T_WAIT: if (slot_free) state_in = swmm_pkg::T_IDLE;
         default: state_in = swmm_pkg::T_IDLE;
      endcase
   end

   always_comb begin
      case (state_ff)
         swmm_pkg::T_RUN:  load = done && emit_ff && slot_free;
         swmm_pkg::T_WAIT: load = slot_free;
         default:          load = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= swmm_pkg::T_IDLE;
         window_size_ff <= 9'd1;
         position_ff    <= '0;
         fill_ff        <= '0;
         emit_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_xfer) begin
            window_size_ff <= csr_window_size;
            fill_ff        <= '0;
         end else if (req_xfer) begin
            fill_ff <= fill_next;
         end
         if (req_xfer) begin
            position_ff <= position_ff + 32'd1;
            emit_ff     <= (32'(fill_next) >= window);
         end
         if (load)           rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         min_ff <= min_status.front;
         max_ff <= max_status.front;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_window_min = min_ff;
   assign rsp_window_max = max_ff;

   a_load_slot: assert property (@(posedge clock) disable iff (reset)
      load |-> slot_free) else $error("result overwritten before transfer");
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (min_status.busy && max_status.busy))
      else $error("queues did not start");
   a_order: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff || ($signed(min_ff) <= $signed(max_ff)))
      else $error("minimum above maximum");

endmodule

// ===== tb/sliding_window_min_max_core_test.sv =====
// Self-checking testbench for the sliding window minimum and maximum core.

class window_scoreboard;
   int unsigned window_len;
   logic [31:0] samples[$];
   int unsigned fill_seen;
   logic [31:0] expected_min[$];
   logic [31:0] expected_max[$];
   int unsigned errors;
   int unsigned results_checked;

   function void reset_state();
      window_len = 1;
      samples.delete();
      fill_seen = 0;
   endfunction

   function void set_window(logic [8:0] value);
      window_len = value;
      if (window_len == 0) window_len = 1;
      if (window_len > 256) window_len = 256;
      samples.delete();
      fill_seen = 0;
   endfunction

   // Keeps the last samples since the latest register write and predicts
   // the window extremes once the window is full.
   function void note_sample(logic [31:0] sample);
      logic signed [31:0] lo;
      logic signed [31:0] hi;
      samples = {samples, sample};
      if (samples.size() > window_len) samples.delete(0);
      if (fill_seen < 256) fill_seen++;
      if (fill_seen >= window_len) begin
         lo = samples[0];
         hi = samples[0];
         foreach (samples[i]) begin
            if ($signed(samples[i]) < lo) lo = samples[i];
            if ($signed(samples[i]) > hi) hi = samples[i];
         end
         expected_min = {expected_min, lo};
         expected_max = {expected_max, hi};
      end
   endfunction

   function void check_result(logic [31:0] got_min, logic [31:0] got_max);
      logic [31:0] want_min;
      logic [31:0] want_max;
      results_checked++;
      if (expected_min.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual min %h max %h",
                  $time, got_min, got_max);
         errors++;
         return;
      end
      want_min = expected_min[0];
      want_max = expected_max[0];
      expected_min.delete(0);
      expected_max.delete(0);
      if (got_min !== want_min) begin
         $display("%0t: window_min expected %h actual %h", $time, want_min, got_min);
         errors++;
      end
      if (got_max !== want_max) begin
         $display("%0t: window_max expected %h actual %h", $time, want_max, got_max);
         errors++;
      end
   endfunction
endclass

module sliding_window_min_max_core_test;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_sample = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_window_min;
   logic [31:0] rsp_window_max;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [8:0]  csr_window_size = '0;

   window_scoreboard board;
   // Percent chances of idling on each side, changed per phase.
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   // When set, the receiver holds off completely for a counted stretch.
   bit          hold_off = 1'b0;
   int unsigned samples_sent = 0;

   sliding_window_min_max_core #(.WINDOW_MAX(256)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_sample(req_sample),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_window_min(rsp_window_min), .rsp_window_max(rsp_window_max),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_window_size(csr_window_size)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver decides ready afresh at every edge, and every accepted
   // result transfer is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_result(rsp_window_min, rsp_window_max);
      rsp_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
   end

   // Sends one sample transfer, with random idle cycles before it. The
   // block is busy right after a transfer, so valid drops before the next one.
   task automatic send_sample(logic [31:0] sample);
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req_valid  <= 1'b1;
      req_sample <= sample;
      do @(posedge clock); while (!req_ready);
      board.note_sample(sample);
      samples_sent++;
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Waits until every predicted result has arrived, then lets the
   // block finish any sample still in flight that yields no result.
   task automatic drain();
      while (board.expected_min.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
   endtask

   // Register writes happen only with the block idle.
   task automatic write_window(logic [8:0] value);
      drain();
      csr_valid       <= 1'b1;
      csr_window_size <= value;
      do @(posedge clock); while (!csr_ready);
      board.set_window(value);
      csr_valid <= 1'b0;
   endtask

   // Half of the values are small with frequent ties, the rest random words or full range extremes.
   function automatic logic [31:0] random_sample();
      case ($urandom_range(3))
         0: return $urandom();
         1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         default: return 32'($signed($urandom_range(16)) - 8);
      endcase
   endfunction

   task automatic random_burst(int unsigned count);
      repeat (count) send_sample(random_sample());
   endtask

   initial begin
      #2_000_000_000;
      $display("sliding_window_min_max_core_test: done, errors");
      $finish;
   end

   initial begin
      int unsigned widths[$];
      board = new();
      board.reset_state();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: window of one at reset, then extremes and ties.
      send_sample(32'h7FFF_FFFF);
      send_sample(32'h8000_0000);
      send_sample(32'h0000_0000);
      send_sample(32'hFFFF_FFFF);
      write_window(9'd3);
      send_sample(32'd5); send_sample(32'd5); send_sample(32'd5);
      send_sample(32'd1); send_sample(32'd2); send_sample(32'd3);
      send_sample(32'd4); send_sample(32'd3); send_sample(32'd2);
      send_sample(32'h8000_0000); send_sample(32'h7FFF_FFFF);
      send_sample(32'hAAAA_AAAA); send_sample(32'h5555_5555);
      // Zero and oversized windows fall back to one and to the maximum.
      write_window(9'd0);
      send_sample(32'd9); send_sample(32'hFFFF_FFF0);
      write_window(9'd511);
      random_burst(20);

      // Random phases across several window lengths and idling mixes.
      widths = '{1, 2, 5, 17, 256, 4, 64, 300, 8, 2};
      foreach (widths[i]) begin
         write_window(widths[i][8:0]);
         case (i % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
            default: begin send_idle_pct = 11; recv_stall_pct = 11; end
         endcase
         if (i == 3) begin
            // Long receiver hold-off while samples keep coming.
            fork
               begin
                  hold_off = 1'b1;
                  repeat (2000) @(posedge clock);
                  hold_off = 1'b0;
               end
               random_burst(60);
            join
         end
         random_burst(widths[i] > 100 ? 260 : 160);
         if (i == 5) begin
            // The sender pauses until every result has come.
            while (board.expected_min.size() != 0) @(posedge clock);
            random_burst(30);
         end
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
      drain();

      $display("Covered %0d samples, %0d results, window lengths 1 to 256 with ties,",
               samples_sent, board.results_checked);
      $display("extremes, register writes and stalls on both sides.");
      if (board.errors == 0 && board.expected_min.size() == 0)
         $display("sliding_window_min_max_core_test: done, clean");
      else
         $display("sliding_window_min_max_core_test: done, errors");
      $finish;
   end
endmodule

// ===== sliding_window_min_max_core.f =====
hw/rtl/swmm_pkg.sv
hw/rtl/swmm_queue.sv
hw/rtl/sliding_window_min_max_core.sv
tb/sliding_window_min_max_core_test.sv
